### design/lbpc_pkg.sv
// Shared types and constants for the LED blink / PWM controller.
// Event codes, duty limits and the fixed-point reciprocal used for the /100 scale.
// No dependencies.
`timescale 1ns / 1ps

package lbpc_pkg;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned PCT_W   = 7;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK      = 3'd0,
    FUNC_BLINK     = 3'd1,
    FUNC_FLASH_ON  = 3'd2,
    FUNC_FLASH_OFF = 3'd3,
    FUNC_SET_FLASH = 3'd4,
    FUNC_SET_LED   = 3'd5,
    FUNC_HOLD      = 3'd6
  } lbpc_func_e;

  localparam logic [PCT_W-1:0] PCT_MAX        = 7'd99;
  localparam logic [PCT_W-1:0] PCT_FULL       = 7'd100;
  localparam logic [PCT_W-1:0] MIN_DUTY_RESET = 7'd10;

  localparam logic [COUNT_W-1:0] LED_BLINK_COUNT = 8'd1;
  localparam logic [MS_W-1:0]    LED_BLINK_MS    = 16'd2000;
  localparam logic [MS_W-1:0]    MS_ONE          = 16'd1;

  // floor(x / 100) == (x * ceil(2^30 / 100)) >> 30 for every x below 2^23
  localparam int unsigned       SCALE_SHIFT = 30;
  localparam longint unsigned   DUTY_RECIP  = ((64'd1 << SCALE_SHIFT) + 64'd99) / 64'd100;
  localparam int unsigned       RECIP_W     = 24;

endpackage

### design/led_blink_pwm_controller.sv
// LED blink / PWM controller: one event in, one status result out per transfer.
// Latency: the result is valid the cycle after the input transfer (state and
// result registers update on the same edge). Throughput: one event per cycle,
// set by the single register stage; input stalls only while a result waits.
// Reset: light mode, unlit, timer stopped, compare 0, paused, min duty 10.
// Depends on lbpc_pkg and lbpc_duty_scale.
`timescale 1ns / 1ps

module led_blink_pwm_controller #(
  parameter int unsigned PWM_BITS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           cfg_we_i,
  input  logic [lbpc_pkg::PCT_W-1:0]     cfg_wdata_i,

  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lbpc_pkg::FUNC_W-1:0]    func_i,
  input  logic [lbpc_pkg::COUNT_W-1:0]   blink_count_i,
  input  logic [lbpc_pkg::MS_W-1:0]      interval_i,
  input  logic [lbpc_pkg::PCT_W-1:0]     duty_i,

  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [PWM_BITS-1:0]            pwm_compare_o,
  output logic                           led_lit_o,
  output logic                           timer_running_o,
  output logic                           flash_mode_o
);

  logic in_fire;

  logic [lbpc_pkg::PCT_W-1:0]   min_duty_q;
  logic                         out_valid_q;

  logic                         mode_flash_q, mode_flash_d;
  logic                         lit_q, lit_d;
  logic [lbpc_pkg::COUNT_W-1:0] blinks_left_q, blinks_left_d;
  logic                         hold_q, hold_d;
  logic                         needs_update_q, needs_update_d;
  logic                         timer_on_q, timer_on_d;
  logic [lbpc_pkg::MS_W-1:0]    period_ms_q, period_ms_d;
  logic [lbpc_pkg::MS_W-1:0]    ms_count_q, ms_count_d;
  logic [lbpc_pkg::PCT_W-1:0]   flash_pct_q, flash_pct_d;
  logic [lbpc_pkg::PCT_W-1:0]   light_pct_q, light_pct_d;
  logic                         paused_q, paused_d;
  logic [PWM_BITS-1:0]          compare_q, compare_d;

  logic [lbpc_pkg::PCT_W-1:0]   ev_pct;
  logic [lbpc_pkg::PCT_W-1:0]   poll_pct;
  logic [PWM_BITS-1:0]          ev_val;
  logic [PWM_BITS-1:0]          poll_val;
  logic [lbpc_pkg::MS_W-1:0]    ms_next;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // flash duty as seen by the event, light duty as seen by the poll
  assign ev_pct   = (func_i == lbpc_pkg::FUNC_SET_FLASH) ? duty_i : flash_pct_q;
  assign poll_pct = (func_i == lbpc_pkg::FUNC_SET_LED)   ? duty_i : light_pct_q;
  assign ms_next  = ms_count_q + lbpc_pkg::MS_ONE;

  lbpc_duty_scale #(
    .PWM_BITS (PWM_BITS)
  ) u_ev_scale (
    .pct_i      (ev_pct),
    .min_duty_i (min_duty_q),
    .compare_o  (ev_val)
  );

  lbpc_duty_scale #(
    .PWM_BITS (PWM_BITS)
  ) u_poll_scale (
    .pct_i      (poll_pct),
    .min_duty_i (min_duty_q),
    .compare_o  (poll_val)
  );

  always_comb begin
    mode_flash_d   = mode_flash_q;
    lit_d          = lit_q;
    blinks_left_d  = blinks_left_q;
    hold_d         = hold_q;
    needs_update_d = needs_update_q;
    timer_on_d     = timer_on_q;
    period_ms_d    = period_ms_q;
    ms_count_d     = ms_count_q;
    flash_pct_d    = flash_pct_q;
    light_pct_d    = light_pct_q;
    paused_d       = paused_q;
    compare_d      = compare_q;

    case (func_i)
      lbpc_pkg::FUNC_TICK: begin
        if (timer_on_q) begin
          if (ms_next >= period_ms_q) begin
            ms_count_d = '0;
            if ((blinks_left_q != '0) && !lit_q) begin
              lit_d          = 1'b1;
              needs_update_d = 1'b1;
            end else if (lit_q) begin
              if (blinks_left_q != '0) begin
                blinks_left_d = blinks_left_q - 1'b1;
              end
              lit_d = 1'b0;
            end
          end else begin
            ms_count_d = ms_next;
          end
        end
      end
      lbpc_pkg::FUNC_BLINK: begin
        lit_d          = 1'b1;
        blinks_left_d  = blink_count_i;
        period_ms_d    = (interval_i == '0) ? lbpc_pkg::MS_ONE : interval_i;
        ms_count_d     = '0;
        timer_on_d     = 1'b1;
        needs_update_d = 1'b1;
      end
      lbpc_pkg::FUNC_FLASH_ON: begin
        mode_flash_d = 1'b1;
        compare_d    = ev_val;
        paused_d     = (ev_val == '0);
      end
      lbpc_pkg::FUNC_FLASH_OFF: begin
        if (mode_flash_q) begin
          mode_flash_d = 1'b0;
          // an off request while paused leaves the compare value alone
          if (!paused_q) begin
            compare_d = '0;
            paused_d  = 1'b1;
          end
          needs_update_d = 1'b1;
        end
      end
      lbpc_pkg::FUNC_SET_FLASH: begin
        flash_pct_d = duty_i;
        if (mode_flash_q) begin
          compare_d = ev_val;
          paused_d  = (ev_val == '0);
        end
      end
      lbpc_pkg::FUNC_SET_LED: begin
        flash_pct_d    = duty_i;
        light_pct_d    = duty_i;
        lit_d          = 1'b1;
        blinks_left_d  = lbpc_pkg::LED_BLINK_COUNT;
        period_ms_d    = lbpc_pkg::LED_BLINK_MS;
        ms_count_d     = '0;
        timer_on_d     = 1'b1;
        needs_update_d = 1'b1;
      end
      lbpc_pkg::FUNC_HOLD: begin
        hold_d = (blink_count_i != '0);
      end
      default: begin
      end
    endcase

    // poll: runs after every event
    if (timer_on_d && (blinks_left_d == '0)) begin
      timer_on_d = 1'b0;
    end
    if (!mode_flash_d) begin
      if (lit_d || hold_d) begin
        if (needs_update_d) begin
          compare_d      = poll_val;
          paused_d       = (poll_val == '0);
          needs_update_d = 1'b0;
        end
      end else begin
        if (!paused_d) begin
          compare_d = '0;
          paused_d  = 1'b1;
        end
        light_pct_d = min_duty_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_duty_q <= lbpc_pkg::MIN_DUTY_RESET;
    end else if (cfg_we_i) begin
      min_duty_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      mode_flash_q   <= 1'b0;
      lit_q          <= 1'b0;
      blinks_left_q  <= '0;
      hold_q         <= 1'b0;
      needs_update_q <= 1'b0;
      timer_on_q     <= 1'b0;
      period_ms_q    <= lbpc_pkg::MS_ONE;
      ms_count_q     <= '0;
      flash_pct_q    <= '0;
      light_pct_q    <= lbpc_pkg::MIN_DUTY_RESET;
      paused_q       <= 1'b1;
      compare_q      <= '0;
    end else begin
      if (in_fire) begin
        out_valid_q    <= 1'b1;
        mode_flash_q   <= mode_flash_d;
        lit_q          <= lit_d;
        blinks_left_q  <= blinks_left_d;
        hold_q         <= hold_d;
        needs_update_q <= needs_update_d;
        timer_on_q     <= timer_on_d;
        period_ms_q    <= period_ms_d;
        ms_count_q     <= ms_count_d;
        flash_pct_q    <= flash_pct_d;
        light_pct_q    <= light_pct_d;
        paused_q       <= paused_d;
        compare_q      <= compare_d;
      end else if (out_ready_i) begin
        // drop the result once transferred
        out_valid_q <= 1'b0;
      end
    end
  end

  // state only moves on an input transfer, so it doubles as the result register
  assign out_valid_o     = out_valid_q;
  assign pwm_compare_o   = compare_q;
  assign led_lit_o       = lit_q;
  assign timer_running_o = timer_on_q;
  assign flash_mode_o    = mode_flash_q;

  a_paused_tracks_compare : assert property (@(posedge clk_i) disable iff (!rst_ni)
    paused_q == (compare_q == '0))
    else $error("paused flag out of step with compare value");

  a_timer_needs_blinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    timer_on_q |-> (blinks_left_q != '0))
    else $error("blink timer running with no blinks left");

  a_result_follows_transfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("input transfer produced no result");

endmodule

### design/lbpc_duty_scale.sv
// Duty percent to PWM compare value: zero stays zero, else clamp to [min_duty, 99],
// then scale by (2^PWM_BITS - 1) / 100 with truncation. Purely combinational.
// Depends on lbpc_pkg.
`timescale 1ns / 1ps

module lbpc_duty_scale #(
  parameter int unsigned PWM_BITS = 10
) (
  input  logic [lbpc_pkg::PCT_W-1:0] pct_i,
  input  logic [lbpc_pkg::PCT_W-1:0] min_duty_i,
  output logic [PWM_BITS-1:0]        compare_o
);

  localparam longint unsigned FULL    = (64'd1 << PWM_BITS) - 64'd1;
  localparam int unsigned     SCALE_W = PWM_BITS + lbpc_pkg::RECIP_W;
  localparam int unsigned     PROD_W  = SCALE_W + lbpc_pkg::PCT_W;
  // full-scale and 1/100 folded into one constant, so one multiply remains
  localparam logic [SCALE_W-1:0] SCALE = SCALE_W'(FULL * lbpc_pkg::DUTY_RECIP);

  logic [lbpc_pkg::PCT_W-1:0] lo;
  logic [lbpc_pkg::PCT_W-1:0] pct_c;
  logic [PROD_W-1:0]          prod;

  always_comb begin
    lo = (min_duty_i > lbpc_pkg::PCT_MAX) ? lbpc_pkg::PCT_MAX : min_duty_i;
    if ((pct_i != '0) && (pct_i < lo)) begin
      pct_c = lo;
    end else if (pct_i >= lbpc_pkg::PCT_FULL) begin
      pct_c = lbpc_pkg::PCT_MAX;
    end else begin
      pct_c = pct_i;
    end
  end

  assign prod      = PROD_W'(SCALE) * PROD_W'(pct_c);
  assign compare_o = prod[lbpc_pkg::SCALE_SHIFT +: PWM_BITS];

endmodule
